[hdl/scar_pkg.sv]
// Package: payload types, register indexes and command/status structs for the reverb.
package scar_pkg;

	localparam int SB = 24;

	// delay memory depths: sum of all comb lines and all allpass lines
	localparam int COMB_DEPTH = 22232;
	localparam int AP_DEPTH   = 3218;

	typedef struct packed {
		logic signed [SB-1:0] left_sample;
		logic signed [SB-1:0] right_sample;
	} in_word_t;

	typedef struct packed {
		logic signed [SB-1:0] left_result;
		logic signed [SB-1:0] right_result;
	} out_word_t;

	localparam logic [2:0] REG_ENABLE   = 3'd0;
	localparam logic [2:0] REG_IN_GAIN  = 3'd1;
	localparam logic [2:0] REG_FEEDBACK = 3'd2;
	localparam logic [2:0] REG_DAMPING  = 3'd3;
	localparam logic [2:0] REG_WET_SAME = 3'd4;
	localparam logic [2:0] REG_WET_X    = 3'd5;
	localparam logic [2:0] REG_DRY      = 3'd6;

	// controller -> datapath
	typedef struct packed {
		logic clr;       // clearing pass write
		logic load;      // capture input word, compute comb input
		logic comb_rd;   // issue comb line read for line idx
		logic comb_wr;   // lowpass/feedback and write back
		logic ap_rd;     // issue allpass read
		logic ap_wr;     // allpass update
		logic mix;       // output mix step
		logic [3:0] idx; // line index
		logic [1:0] sub; // sub step for multi-cycle ops
	} cmd_t;

	typedef struct packed {
		logic clr_done;
	} sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647) return 32'sh7fffffff;
		else if (x < -64'sd2147483648) return 32'sh80000000;
		else return x[31:0];
	endfunction

endpackage

[hdl/scar_datapath.sv]
// Datapath: delay memories, lowpass states, positions and the multiply/accumulate path.
module scar_datapath #(
	parameter int COMB_DEPTH = 22232,
	parameter int AP_DEPTH   = 3218,
	parameter int CA_W       = 15,
	parameter int AA_W       = 12,
	parameter int POS_W      = 11,
	parameter logic [16*CA_W-1:0] COMB_BASE = '0,
	parameter logic [16*POS_W-1:0] COMB_LEN = '0,
	parameter logic [8*AA_W-1:0]  AP_BASE = '0,
	parameter logic [8*POS_W-1:0] AP_LEN = '0
) (
	input  logic clk,
	input  logic arst_n,
	input  scar_pkg::cmd_t cmd,
	output scar_pkg::sts_t sts,
	input  scar_pkg::in_word_t in_word,
	input  logic [15:0] input_gain,
	input  logic [15:0] comb_feedback,
	input  logic [15:0] damping,
	input  logic [15:0] wet_same,
	input  logic [15:0] wet_cross,
	input  logic [15:0] dry_gain,
	output scar_pkg::out_word_t out_word
);
	logic signed [31:0] comb_mem [COMB_DEPTH];
	logic signed [31:0] ap_mem [AP_DEPTH];
	logic signed [31:0] comb_rd_q, ap_rd_q;
	logic signed [31:0] lp_q [16];
	logic [POS_W-1:0] pos_q [24];
	logic [CA_W-1:0] clr_addr_q;
	logic signed [scar_pkg::SB-1:0] xl_q, xr_q;
	logic signed [31:0] cin_q;
	logic signed [63:0] acc_q [2];
	logic signed [63:0] prod_q;
	logic signed [31:0] f_q;

	logic [POS_W-1:0] clen, alen, cpos, apos;
	logic [4:0] cslot, aslot;
	logic [CA_W-1:0] caddr;
	logic [AA_W-1:0] aaddr;
	logic signed [31:0] a_cur;
	logic signed [63:0] lp_sum, res;

	function automatic logic signed [scar_pkg::SB-1:0] sat24(input logic signed [63:0] p);
		logic signed [63:0] r;
		r = (p + 64'sd16384) >>> 15;
		if (r > 64'sd8388607) return 24'sh7fffff;
		else if (r < -64'sd8388608) return 24'sh800000;
		else return r[scar_pkg::SB-1:0];
	endfunction

	always_comb begin
		cslot = {1'b0, cmd.idx};
		aslot = {2'b10, cmd.idx[2:0]};
		clen = COMB_LEN[cmd.idx*POS_W +: POS_W];
		alen = AP_LEN[cmd.idx[2:0]*POS_W +: POS_W];
		cpos = (pos_q[cslot] >= clen) ? '0 : pos_q[cslot];
		apos = (pos_q[aslot] >= alen) ? '0 : pos_q[aslot];
		caddr = COMB_BASE[cmd.idx*CA_W +: CA_W] + CA_W'(cpos);
		aaddr = AP_BASE[cmd.idx[2:0]*AA_W +: AA_W] + AA_W'(apos);
		a_cur = acc_q[cmd.idx[2]][31:0];
		lp_sum = 64'(comb_rd_q) * $signed({1'b0, 17'h10000 - {1'b0, damping}})
			+ 64'(lp_q[cmd.idx]) * $signed({1'b0, damping});
		res = acc_q[cmd.idx[0]] * $signed({1'b0, wet_same});
	end

	assign sts.clr_done = (clr_addr_q == CA_W'(COMB_DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			for (int i = 0; i < 24; i++) pos_q[i] <= '0;
			for (int i = 0; i < 16; i++) lp_q[i] <= '0;
		end else begin
			if (cmd.clr && !sts.clr_done) clr_addr_q <= clr_addr_q + 1'b1;
			if (cmd.comb_wr && cmd.sub == 2'd0)
				lp_q[cmd.idx] <= scar_pkg::sat32((lp_sum + 64'sd32768) >>> 16);
			// position moves on in the write back step, which still uses the current tap
			if (cmd.comb_wr && cmd.sub == 2'd2)
				pos_q[cslot] <= (32'(cpos) + 1 >= 32'(clen)) ? '0 : cpos + 1'b1;
			if (cmd.ap_wr)
				pos_q[aslot] <= (32'(apos) + 1 >= 32'(alen)) ? '0 : apos + 1'b1;
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (cmd.clr)
			comb_mem[clr_addr_q] <= '0;
		else if (cmd.comb_wr && cmd.sub == 2'd2)
			comb_mem[caddr] <= scar_pkg::sat32(64'(cin_q) + ((prod_q + 64'sd32768) >>> 16));
		if (cmd.clr) begin
			if (32'(clr_addr_q) < AP_DEPTH) ap_mem[clr_addr_q[AA_W-1:0]] <= '0;
		end else if (cmd.ap_wr)
			ap_mem[aaddr] <= scar_pkg::sat32(64'(a_cur) + ((64'(ap_rd_q) + 64'sd1) >>> 1));
		comb_rd_q <= comb_mem[caddr];
		ap_rd_q <= ap_mem[aaddr];
	end

	// arithmetic sequence
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			xl_q <= in_word.left_sample;
			xr_q <= in_word.right_sample;
			cin_q <= scar_pkg::sat32(((64'(in_word.left_sample) + 64'(in_word.right_sample))
				* $signed({1'b0, input_gain}) + 64'sd32768) >>> 16);
			acc_q[0] <= '0;
			acc_q[1] <= '0;
		end
		if (cmd.comb_wr) begin
			case (cmd.sub)
				2'd0: begin
					acc_q[cmd.idx[3]] <= acc_q[cmd.idx[3]] + 64'(comb_rd_q);
					f_q <= scar_pkg::sat32((lp_sum + 64'sd32768) >>> 16);
				end
				2'd1: prod_q <= 64'(f_q) * $signed({1'b0, comb_feedback});
				default: ;
			endcase
		end
		if (cmd.comb_wr && cmd.sub == 2'd2 && cmd.idx == 4'd15) begin
			acc_q[0] <= 64'(scar_pkg::sat32(acc_q[0]));
			acc_q[1] <= 64'(scar_pkg::sat32(acc_q[1]));
		end
		if (cmd.ap_wr)
			acc_q[cmd.idx[2]] <= 64'(scar_pkg::sat32(64'(ap_rd_q) - 64'(a_cur)));
		if (cmd.mix) begin
			// idx[0] picks the channel: own reverb, then the other side's
			case (cmd.sub)
				2'd0: prod_q <= res;
				2'd1: prod_q <= 2 * (prod_q + acc_q[~cmd.idx[0]]
					* $signed({1'b0, wet_cross}))
					+ 64'(cmd.idx[0] ? xr_q : xl_q) * $signed({1'b0, dry_gain});
				default: begin
					if (cmd.idx[0]) out_word.right_result <= sat24(prod_q);
					else out_word.left_result <= sat24(prod_q);
				end
			endcase
		end
	end
endmodule

[hdl/scar_ctrl.sv]
// Controller: clearing pass and the per-word step sequence.
module scar_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  scar_pkg::sts_t sts,
	input  logic start,
	input  logic bypass,
	input  logic out_free,
	output scar_pkg::cmd_t cmd,
	output logic busy,
	output logic done
);
	localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_CRD = 3'd2, S_CWR = 3'd3,
		S_ARD = 3'd4, S_AWR = 3'd5, S_MIX = 3'd6, S_DONE = 3'd7;
	logic [2:0] state_q;
	logic [3:0] idx_q;
	logic [1:0] sub_q;

	always_comb begin
		cmd = '0;
		cmd.idx = idx_q;
		cmd.sub = sub_q;
		case (state_q)
			S_CLR: cmd.clr = 1'b1;
			S_IDLE: cmd.load = start && !bypass;
			S_CRD: cmd.comb_rd = 1'b1;
			S_CWR: cmd.comb_wr = 1'b1;
			S_ARD: cmd.ap_rd = 1'b1;
			S_AWR: cmd.ap_wr = 1'b1;
			S_MIX: cmd.mix = 1'b1;
			default: ;
		endcase
		busy = (state_q != S_IDLE);
		done = (state_q == S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			idx_q <= '0;
			sub_q <= '0;
		end else begin
			case (state_q)
				S_CLR: if (sts.clr_done) state_q <= S_IDLE;
				S_IDLE: if (start && !bypass) begin
					state_q <= S_CRD;
					idx_q <= '0;
					sub_q <= '0;
				end
				S_CRD: state_q <= S_CWR;
				S_CWR: begin
					sub_q <= sub_q + 1'b1;
					if (sub_q == 2'd2) begin
						sub_q <= '0;
						idx_q <= idx_q + 1'b1;
						state_q <= (idx_q == 4'd15) ? S_ARD : S_CRD;
					end
				end
				S_ARD: state_q <= S_AWR;
				S_AWR: begin
					// allpass order: left 0..3 then right 0..3 (idx[2] picks channel)
					idx_q <= idx_q + 1'b1;
					if (idx_q == 4'd7) begin
						idx_q <= '0;
						state_q <= S_MIX;
					end else
						state_q <= S_ARD;
				end
				S_MIX: begin
					sub_q <= sub_q + 1'b1;
					if (sub_q == 2'd2) begin
						sub_q <= '0;
						idx_q <= idx_q + 1'b1;
						if (idx_q == 4'd1) state_q <= S_DONE;
					end
				end
				S_DONE: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[hdl/stereo_comb_allpass_reverb_top.sv]
// Top level: config registers, word handshakes, controller and datapath.
//  channel | signals                                 | direction
//  in      | in_valid/in_ready, in_data              | word in
//  out     | out_valid/out_ready, out_data           | word out
//  cfg     | cfg_valid/cfg_ready, cfg_index/cfg_data | register write
// Processed word: out_valid after 16 comb lines (read, lowpass, feedback multiply, write
// back), 8 allpasses (read, update), mix and handoff; no word is taken meanwhile.
// Bypassed word: out_valid the cycle after the take.
// Reset: the comb and allpass memories are cleared first, one entry a cycle; no words
// are taken until then, config writes are taken throughout.
// Stalls: out register holds while out_ready is low; a processed word may still be taken.
module stereo_comb_allpass_reverb_top (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  scar_pkg::in_word_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output scar_pkg::out_word_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int CA_W = $clog2(scar_pkg::COMB_DEPTH);
	localparam int AA_W = $clog2(scar_pkg::AP_DEPTH);
	localparam int PW = 11;
	localparam logic [16*PW-1:0] CLEN = {11'd1640, 11'd1580, 11'd1514, 11'd1445,
		11'd1379, 11'd1300, 11'd1211, 11'd1139,
		11'd1617, 11'd1557, 11'd1491, 11'd1422, 11'd1356, 11'd1277, 11'd1188, 11'd1116};
	localparam logic [16*CA_W-1:0] CBASE = {15'd20592, 15'd19012, 15'd17498, 15'd16053,
		15'd14674, 15'd13374, 15'd12163, 15'd11024,
		15'd9407, 15'd7850, 15'd6359, 15'd4937, 15'd3581, 15'd2304, 15'd1116, 15'd0};
	localparam logic [8*PW-1:0] ALEN = {11'd248, 11'd364, 11'd464, 11'd579,
		11'd225, 11'd341, 11'd441, 11'd556};
	localparam logic [8*AA_W-1:0] ABASE = {12'd2970, 12'd2606, 12'd2142, 12'd1563,
		12'd1338, 12'd997, 12'd556, 12'd0};

	logic enable_q;
	logic [15:0] gain_q, fb_q, damp_q, ws_q, wx_q, dry_q;
	logic bypass, start, busy, done, out_free;
	scar_pkg::cmd_t cmd;
	scar_pkg::sts_t sts;
	scar_pkg::out_word_t dp_out;

	assign cfg_ready = 1'b1;
	assign bypass = !enable_q || (ws_q == '0 && wx_q == '0);
	// out register is free if empty or being drained this cycle
	assign out_free = !out_valid || out_ready;
	// a bypassed word lands in the out register at once; a processed one later
	assign in_ready = !busy && (!bypass || out_free);
	assign start = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			gain_q <= 16'd983;
			fb_q <= 16'd55050;
			damp_q <= 16'd13107;
			ws_q <= 16'd16384;
			wx_q <= '0;
			dry_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					scar_pkg::REG_ENABLE: enable_q <= cfg_data[0];
					scar_pkg::REG_IN_GAIN: gain_q <= cfg_data;
					scar_pkg::REG_FEEDBACK: fb_q <= cfg_data;
					scar_pkg::REG_DAMPING: damp_q <= cfg_data;
					scar_pkg::REG_WET_SAME: ws_q <= cfg_data;
					scar_pkg::REG_WET_X: wx_q <= cfg_data;
					scar_pkg::REG_DRY: dry_q <= cfg_data;
					default: ;
				endcase
			end
			if (done || (start && bypass)) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	// out register: the bypassed word or the datapath result
	always_ff @(posedge clk) begin
		if (start && bypass) begin
			out_data.left_result <= in_data.left_sample;
			out_data.right_result <= in_data.right_sample;
		end else if (done)
			out_data <= dp_out;
	end

	scar_ctrl u_ctrl (.clk, .arst_n, .sts, .start, .bypass, .out_free, .cmd, .busy, .done);

	scar_datapath #(.COMB_DEPTH(scar_pkg::COMB_DEPTH), .AP_DEPTH(scar_pkg::AP_DEPTH),
		.CA_W(CA_W), .AA_W(AA_W),
		.POS_W(PW), .COMB_BASE(CBASE), .COMB_LEN(CLEN), .AP_BASE(ABASE), .AP_LEN(ALEN)) u_dp (
		.clk, .arst_n, .cmd, .sts, .in_word(in_data), .input_gain(gain_q),
		.comb_feedback(fb_q), .damping(damp_q), .wet_same(ws_q), .wet_cross(wx_q),
		.dry_gain(dry_q), .out_word(dp_out));
endmodule

[hdl/scar_checker.sv]
// Port checker for the reverb top level, with its bind.
module scar_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input scar_pkg::out_word_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out held");
	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown(out_data)) else $error("out data unknown");
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready || out_valid) else $error("in_ready after take");
endmodule

bind stereo_comb_allpass_reverb_top scar_checker u_chk (.clk, .arst_n, .in_valid, .in_ready,
	.out_valid, .out_ready, .out_data);

[tb/tb_stereo_comb_allpass_reverb_top.sv]
// Testbench for the stereo comb/allpass reverb: directed, back-pressure, random and pause tests.
module tb_stereo_comb_allpass_reverb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Line lengths at 44.1 kHz; the right channel's lines are longer by the spread.
	localparam int SPREAD = 23;
	localparam int COMB_WORDS = 22232;
	localparam int AP_WORDS = 3218;
	localparam int COMB_TUNE [8] = '{1116, 1188, 1277, 1356, 1422, 1491, 1557, 1617};
	localparam int AP_TUNE [4] = '{556, 441, 341, 225};
	localparam int DRAIN_CYCLES = 120;   // longer than a processed word takes

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	scar_pkg::in_word_t in_data;
	logic out_valid;
	logic out_ready;
	scar_pkg::out_word_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;

	stereo_comb_allpass_reverb_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ---------------------------------------------------------------
	// Predictor state: its own copy of the registers and delay lines
	// ---------------------------------------------------------------
	logic        reg_enable;
	logic [15:0] reg_in_gain, reg_feedback, reg_damping;
	logic [15:0] reg_wet_same, reg_wet_x, reg_dry;
	int          comb_mem [COMB_WORDS];
	int          ap_mem [AP_WORDS];
	int          lowpass [16];
	int          line_pos [24];

	scar_pkg::out_word_t expected_frames [$];
	int          mismatches;

	function automatic longint round_shift(longint x, int s);
		return (x + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clip(longint x, int bits);
		longint hi, lo;
		hi = (64'sd1 <<< (bits - 1)) - 1;
		lo = -hi - 1;
		return (x > hi) ? hi : ((x < lo) ? lo : x);
	endfunction

	// Returns the current tap of a line and advances its position.
	function automatic int tap_advance(int slot, int len);
		int p;
		p = line_pos[slot];
		if (p >= len)
			p = 0;
		line_pos[slot] = (p + 1 >= len) ? 0 : p + 1;
		return p;
	endfunction

	function automatic void clear_model();
		reg_enable = 1'b1;
		reg_in_gain = 16'd983;
		reg_feedback = 16'd55050;
		reg_damping = 16'd13107;
		reg_wet_same = 16'd16384;
		reg_wet_x = 16'd0;
		reg_dry = 16'd0;
		foreach (comb_mem[i]) comb_mem[i] = 0;
		foreach (ap_mem[i]) ap_mem[i] = 0;
		foreach (lowpass[i]) lowpass[i] = 0;
		foreach (line_pos[i]) line_pos[i] = 0;
	endfunction

	function automatic void apply_reg(logic [2:0] idx, logic [15:0] v);
		case (idx)
			scar_pkg::REG_ENABLE:   reg_enable = v[0];
			scar_pkg::REG_IN_GAIN:  reg_in_gain = v;
			scar_pkg::REG_FEEDBACK: reg_feedback = v;
			scar_pkg::REG_DAMPING:  reg_damping = v;
			scar_pkg::REG_WET_SAME: reg_wet_same = v;
			scar_pkg::REG_WET_X:    reg_wet_x = v;
			scar_pkg::REG_DRY:      reg_dry = v;
			default: ;
		endcase
	endfunction

	function automatic scar_pkg::out_word_t reverb_frame(scar_pkg::in_word_t w);
		longint x [2];
		longint acc [2];
		longint cin, o, f, b, a, wet, res, damp2;
		int base, len, p;
		scar_pkg::out_word_t r;
		x[0] = w.left_sample;
		x[1] = w.right_sample;
		if (!reg_enable || (reg_wet_same == 0 && reg_wet_x == 0)) begin
			r.left_result = w.left_sample;
			r.right_result = w.right_sample;
			return r;
		end
		damp2 = 65536 - longint'(reg_damping);
		cin = clip(round_shift((x[0] + x[1]) * longint'(reg_in_gain), 16), 32);
		acc[0] = 0;
		acc[1] = 0;
		base = 0;
		for (int k = 0; k < 16; k++) begin
			len = COMB_TUNE[k % 8] + ((k >= 8) ? SPREAD : 0);
			p = tap_advance(k, len);
			o = comb_mem[base + p];
			f = clip(round_shift(o * damp2 + longint'(lowpass[k]) * longint'(reg_damping),
				16), 32);
			lowpass[k] = int'(f);
			comb_mem[base + p] = int'(clip(cin + round_shift(f * longint'(reg_feedback), 16),
				32));
			acc[k / 8] += o;
			base += len;
		end
		acc[0] = clip(acc[0], 32);
		acc[1] = clip(acc[1], 32);
		base = 0;
		for (int k = 0; k < 8; k++) begin
			len = AP_TUNE[k % 4] + ((k >= 4) ? SPREAD : 0);
			p = tap_advance(16 + k, len);
			b = ap_mem[base + p];
			a = acc[k / 4];
			ap_mem[base + p] = int'(clip(a + round_shift(b, 1), 32));
			acc[k / 4] = clip(b - a, 32);
			base += len;
		end
		for (int ch = 0; ch < 2; ch++) begin
			wet = acc[ch] * longint'(reg_wet_same) + acc[1 - ch] * longint'(reg_wet_x);
			res = clip(round_shift(2 * wet + x[ch] * longint'(reg_dry), 15), 24);
			if (ch == 0)
				r.left_result = res[23:0];
			else
				r.right_result = res[23:0];
		end
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Monitor: predict on each accepted input word, check each output word.
	// Inputs are handled before outputs so the order within an edge is fixed.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		scar_pkg::out_word_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				apply_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				expected_frames.push_back(reverb_frame(in_data));
			if (out_valid && out_ready) begin
				if (expected_frames.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word L=%0d R=%0d",
							out_data.left_result, out_data.right_result);
				end else begin
					want = expected_frames.pop_front();
					if (want.left_result !== out_data.left_result
						|| want.right_result !== out_data.right_result) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected L=%0d R=%0d, got L=%0d R=%0d",
								want.left_result, want.right_result,
								out_data.left_result, out_data.right_result);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Receiver: stalls in changing patterns; a long hold-off on request.
	// ---------------------------------------------------------------
	int hold_req;        // cycles of forced stall, set by a test
	int hold_left;
	int pattern_left;
	int pattern;

	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (pattern_left == 0) begin
			pattern = $urandom_range(0, 3);
			pattern_left = $urandom_range(20, 300);
		end
		pattern_left--;
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (pattern)
				0: out_ready <= 1'b1;                       // no stalls
				1: out_ready <= ($urandom_range(0, 1) == 1);
				2: out_ready <= ($urandom_range(0, 7) != 0);
				default: out_ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Sender helpers
	// ---------------------------------------------------------------
	int burst_left;

	// Sends one word; between bursts the input may go idle for a random gap.
	task automatic send_word(logic [23:0] l, logic [23:0] r);
		int gap;
		in_valid <= 1'b1;
		in_data.left_sample <= l;
		in_data.right_sample <= r;
		do @(posedge clk); while (!in_ready);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else
			burst_left--;
	endtask

	// Waits until every expected word is back, then lets the datapath settle.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_frames.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Valid drops for one cycle after each write.
	task automatic write_reg(logic [2:0] idx, logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [23:0] rand_sample();
		case ($urandom_range(0, 4))
			0: return 24'($urandom());
			1: return 24'($signed($urandom_range(0, 2000)) - 1000);
			2: return ($urandom_range(0, 1) == 1) ? 24'h7fffff : 24'h800000;
			default: return 24'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
		endcase
	endfunction

	function automatic logic [15:0] pick_gain(logic [15:0] top);
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return top;
			default: return 16'($urandom_range(0, top));
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	task automatic test_directed();
		// reset settings: extremes of the samples and an impulse
		send_word(24'h7fffff, 24'h7fffff);
		send_word(24'h800000, 24'h800000);
		send_word(24'h7fffff, 24'h800000);
		send_word(24'h000000, 24'h000000);
		send_word(24'h100000, 24'h000000);
		drain();
		// disabled: straight pass-through, state held
		write_reg(scar_pkg::REG_ENABLE, 16'd0);
		write_reg(scar_pkg::REG_DRY, 16'd32768);
		send_word(24'h123456, 24'hfedcba);
		send_word(24'h800000, 24'h7fffff);
		drain();
		// enabled but both wet gains zero: also pass-through
		write_reg(scar_pkg::REG_ENABLE, 16'd1);
		write_reg(scar_pkg::REG_WET_SAME, 16'd0);
		send_word(24'h654321, 24'h000001);
		drain();
		// gains and feedback at their top, no damping: internal and output saturation
		write_reg(scar_pkg::REG_IN_GAIN, 16'hffff);
		write_reg(scar_pkg::REG_FEEDBACK, 16'hffff);
		write_reg(scar_pkg::REG_DAMPING, 16'd0);
		write_reg(scar_pkg::REG_WET_SAME, 16'hffff);
		write_reg(scar_pkg::REG_WET_X, 16'hffff);
		repeat (4) send_word(24'h7fffff, 24'h7fffff);
		repeat (4) send_word(24'h800000, 24'h800000);
		drain();
		// full damping, no input gain: only the dry path and stored energy
		write_reg(scar_pkg::REG_DAMPING, 16'hffff);
		write_reg(scar_pkg::REG_IN_GAIN, 16'd0);
		write_reg(scar_pkg::REG_FEEDBACK, 16'd0);
		send_word(24'h400000, 24'hc00000);
		send_word(24'h000000, 24'h7fffff);
		drain();
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 10; ph++) begin
			drain();
			write_reg(scar_pkg::REG_ENABLE,
				($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom() | 1));
			write_reg(scar_pkg::REG_IN_GAIN, pick_gain(16'hffff));
			write_reg(scar_pkg::REG_FEEDBACK, pick_gain(16'hffff));
			write_reg(scar_pkg::REG_DAMPING, pick_gain(16'hffff));
			write_reg(scar_pkg::REG_WET_SAME, pick_gain(16'hffff));
			write_reg(scar_pkg::REG_WET_X, pick_gain(16'hffff));
			write_reg(scar_pkg::REG_DRY, pick_gain(16'd32768));
			repeat (95) send_word(rand_sample(), rand_sample());
		end
		drain();
	endtask

	// Receiver holds off while the sender keeps offering words.
	task automatic test_backpressure();
		write_reg(scar_pkg::REG_ENABLE, 16'd1);
		write_reg(scar_pkg::REG_WET_SAME, 16'd16384);
		write_reg(scar_pkg::REG_WET_X, 16'd8192);
		hold_req = 600;
		for (int i = 0; i < 20; i++) begin
			in_valid <= 1'b1;
			in_data.left_sample <= rand_sample();
			in_data.right_sample <= rand_sample();
			do @(posedge clk); while (!in_ready);
		end
		drain();
	endtask

	// Sender stops mid-stream until every result is back, then resumes.
	task automatic test_pause();
		repeat (15) send_word(rand_sample(), rand_sample());
		drain();
		repeat (15) send_word(rand_sample(), rand_sample());
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = scar_pkg::REG_ENABLE;
		cfg_data = '0;
		mismatches = 0;
		hold_req = 0;
		hold_left = 0;
		pattern_left = 0;
		pattern = 0;
		burst_left = 0;
		clear_model();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_random();
		test_pause();

		drain();
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Generous limit: clearing pass plus about a thousand slow words with stalls.
	initial begin
		#10ms;
		$display("Some tests failed");
		$finish;
	end

endmodule
